### hw/rtl/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg
// Shared constants, types and the arctangent table of the swerve kinematics.
// ----------------------------------------------------------------------------
`default_nettype none

package swk_pkg;

  localparam int DefSampleBits  = 16;
  localparam int DefCordicSteps = 16;

  localparam int InFracBits = 15;
  localparam int AngW       = 34;
  localparam int RatioW     = 31;
  localparam int QuotW      = 17;
  localparam int CfgW       = 12;
  localparam int CfgIdxW    = 8;
  localparam int Lanes      = 4;
  localparam int HalfQ30    = 1 << 29;
  localparam int AngRound   = 1 << 16;
  localparam int AngShift   = 17;

  localparam logic [CfgIdxW-1:0] RegLength = 8'd0;
  localparam logic [CfgIdxW-1:0] RegWidth  = 8'd1;

  localparam logic [CfgW-1:0] LengthReset = 12'd500;
  localparam logic [CfgW-1:0] WidthReset  = 12'd500;

  localparam logic [RatioW-1:0] InvGain = 31'd652032875;

  localparam logic signed [AngW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [AngShift-1:0] AngMax  = 17'sd16384;
  localparam logic signed [AngShift-1:0] AngMin  = -17'sd16384;
  localparam logic [QuotW-1:0] SpeedMax          = 17'd32768;

  typedef struct packed {
    logic              busy;
    logic [RatioW-1:0] len_ratio;
    logic [RatioW-1:0] wid_ratio;
  } ratio_t;

  // arctangent of 2^-idx, 2^32 per turn
  function automatic logic signed [AngW-1:0] atan_angle(input int idx);
    logic signed [AngW-1:0] a;
    case (idx)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/swk_cordic_cell.sv
// ----------------------------------------------------------------------------
// swk_cordic_cell
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module swk_cordic_cell
  import swk_pkg::*;
#(
  parameter int WW     = 25,
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                   clk_i,
  input  wire logic                   ce_i,
  input  wire logic signed [WW-1:0]   x_i,
  input  wire logic signed [WW-1:0]   y_i,
  input  wire logic signed [AngW-1:0] z_i,
  output logic signed [WW-1:0]        x_o,
  output logic signed [WW-1:0]        y_o,
  output logic signed [AngW-1:0]      z_o
);

  logic                   neg;
  logic signed [WW-1:0]   dx;
  logic signed [WW-1:0]   dy;
  logic signed [AngW-1:0] ang;

  // vectoring drives y to zero, rotation drives z to zero
  assign neg = VECTOR ? !y_i[WW-1] : z_i[AngW-1];
  assign dx  = y_i >>> STEP;
  assign dy  = x_i >>> STEP;
  assign ang = atan_angle(STEP);

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (neg) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + ang;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - ang;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swk_div_cell.sv
// ----------------------------------------------------------------------------
// swk_div_cell
// One registered restoring-division step, yields one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module swk_div_cell
  import swk_pkg::*;
#(
  parameter int DW  = 24,
  parameter int NW  = 40,
  parameter int BIT = 0
) (
  input  wire logic             clk_i,
  input  wire logic             ce_i,
  input  wire logic [DW-1:0]    rem_i,
  input  wire logic [NW-1:0]    num_i,
  input  wire logic [DW-1:0]    den_i,
  input  wire logic [QuotW-1:0] quo_i,
  output logic [DW-1:0]         rem_o,
  output logic [NW-1:0]         num_o,
  output logic [DW-1:0]         den_o,
  output logic [QuotW-1:0]      quo_o
);

  logic [DW:0] rem2;
  logic [DW:0] diff;
  logic        ge;

  assign rem2 = {rem_i, num_i[BIT]};
  assign diff = rem2 - {1'b0, den_i};
  assign ge   = rem2 >= {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_o <= ge ? diff[DW-1:0] : rem2[DW-1:0];
      num_o <= num_i;
      den_o <= den_i;
      quo_o <= quo_i | (QuotW'(ge) << BIT);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/swk_ratio.sv
// ----------------------------------------------------------------------------
// swk_ratio
// Sequential unit for length/diagonal and width/diagonal in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module swk_ratio
  import swk_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [CfgW-1:0] length_i,
  input  wire logic [CfgW-1:0] width_i,
  output ratio_t               ratio_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StInit = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StSqrt = 2'd3;

  localparam logic [5:0] DivSteps  = 6'd60;
  localparam logic [5:0] SqrtSteps = 6'd31;

  logic [1:0]  state_q;
  logic        phase_q;
  logic [5:0]  cnt_q;
  logic [24:0] s_q;
  logic [24:0] rem_q;
  logic [60:0] quo_q;
  logic [60:0] n_q;
  logic [61:0] res_q;
  logic [60:0] bit_q;
  logic [RatioW-1:0] len_q;
  logic [RatioW-1:0] wid_q;

  logic [23:0] sq_l;
  logic [23:0] sq_w;
  logic [24:0] sum;
  logic [24:0] num_sq;
  logic        q0;
  logic [25:0] rem2;
  logic        ge;
  logic [61:0] trial;
  logic        ge2;

  assign sq_l   = 24'(length_i) * 24'(length_i);
  assign sq_w   = 24'(width_i) * 24'(width_i);
  assign sum    = {1'b0, sq_l} + {1'b0, sq_w};
  assign num_sq = phase_q ? {1'b0, sq_w} : {1'b0, sq_l};
  assign q0     = num_sq >= sum;
  assign rem2   = {rem_q, 1'b0};
  assign ge     = rem2 >= {1'b0, s_q};
  assign trial  = res_q + {1'b0, bit_q};
  assign ge2    = {1'b0, n_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= StInit;
      phase_q <= 1'b0;
    end else begin
      case (state_q)
        StInit: begin
          if (sum == '0) begin
            state_q <= phase_q ? StIdle : StInit;
            phase_q <= 1'b1;
          end else begin
            state_q <= StDiv;
            cnt_q   <= DivSteps;
          end
        end
        StDiv: begin
          if (cnt_q == '0) begin
            state_q <= StSqrt;
            cnt_q   <= SqrtSteps;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        StSqrt: begin
          if (cnt_q == '0) begin
            state_q <= phase_q ? StIdle : StInit;
            phase_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StInit: begin
        s_q   <= sum;
        rem_q <= q0 ? num_sq - sum : num_sq;
        quo_q <= {60'd0, q0};
        if (sum == '0) begin
          if (phase_q) wid_q <= '0;
          else len_q <= '0;
        end
      end
      StDiv: begin
        if (cnt_q != '0) begin
          rem_q <= ge ? 25'(rem2 - {1'b0, s_q}) : rem2[24:0];
          quo_q <= {quo_q[59:0], ge};
        end else begin
          n_q   <= quo_q;
          res_q <= '0;
          bit_q <= 61'd1 << 60;
        end
      end
      StSqrt: begin
        if (cnt_q != '0) begin
          if (ge2) begin
            n_q   <= n_q - trial[60:0];
            res_q <= (res_q >> 1) + {1'b0, bit_q};
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else if (phase_q) begin
          wid_q <= res_q[RatioW-1:0];
        end else begin
          len_q <= res_q[RatioW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign ratio_o.busy      = (state_q != StIdle) || start_i;
  assign ratio_o.len_ratio = len_q;
  assign ratio_o.wid_ratio = wid_q;

endmodule

`default_nettype wire

### hw/rtl/swerve_wheel_kinematics_top.sv
// Throughput: one word per cycle while the ratio unit is idle; the datapath is a row of
// registers and registered CORDIC and division cells, stalled only when the output
// register is held. Reset: control clears at once; the ratio unit then computes both
// ratios with s_axis_tready low, as it does again after a configuration write.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics_top
// Swerve drive inverse kinematics: field rotation, rotate mixing, per-wheel
// magnitude and angle, speed normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module swerve_wheel_kinematics_top
  import swk_pkg::*;
#(
  parameter int SAMPLE_BITS  = DefSampleBits,
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // strafe, forward, rotate, heading
  input  wire logic [63:0]        s_axis_tdata,
  // heading_valid
  input  wire logic [0:0]         s_axis_tuser,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // front_left_speed, front_right_speed, rear_left_speed, rear_right_speed,
  // front_left_angle, front_right_angle, rear_left_angle, rear_right_angle
  output logic [127:0]            m_axis_tdata,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  localparam int WF     = SAMPLE_BITS + 4;
  localparam int WW     = WF + 5;
  localparam int DW     = WW - 1;
  localparam int NW     = DW + 16;
  localparam int Steps  = CORDIC_STEPS;
  localparam int StG1   = Steps + 1;
  localparam int StG2   = 2 * Steps + 3;
  localparam int StM    = StG2 + 1;
  localparam int StA    = StM + 1;
  localparam int StVp   = StA + 1;
  localparam int StVg   = StVp + Steps + 1;
  localparam int StMx   = StVg + 1;
  localparam int StLast = StMx + QuotW;
  localparam int NStage = StLast + 1;
  localparam int SmallHalf = 1 << (WF - InFracBits - 1);

  typedef struct packed {
    logic signed [WW-1:0] x;
    logic signed [WW-1:0] y;
    logic signed [WW-1:0] rot;
    logic                 hv;
    logic [1:0]           quad;
    logic signed [31:0]   resid;
  } side_t;

  typedef struct packed {
    logic                 big;
    logic [Lanes-1:0][15:0] plain_spd;
    logic [Lanes-1:0][15:0] ang;
  } tail_t;

  function automatic logic signed [WW-1:0] mul_round(input logic signed [WW-1:0] v,
                                                       input logic [RatioW-1:0] r);
    logic signed [WW+RatioW:0] p;
    p = v * $signed({1'b0, r});
    p = p + (WW+RatioW+1)'(HalfQ30);
    return WW'(p >>> 30);
  endfunction

  // ---------------------------------------------------------------- control
  logic              adv;
  logic              in_fire;
  logic [NStage-1:0] vld_q;
  logic              out_vld_q;
  logic [127:0]      out_data_q;
  logic [CfgW-1:0]   len_q;
  logic [CfgW-1:0]   wid_q;
  logic              start_q;
  logic              cfg_fire;
  ratio_t            rat;

  assign adv           = !out_vld_q || m_axis_tready || !vld_q[StLast];
  assign s_axis_tready = adv && !rat.busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LengthReset;
      wid_q   <= WidthReset;
      start_q <= 1'b0;
    end else begin
      start_q <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_index_i)
          RegLength: len_q <= cfg_data_i;
          RegWidth:  wid_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  swk_ratio u_ratio (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .length_i (len_q),
    .width_i  (wid_q),
    .ratio_o  (rat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) vld_q <= {vld_q[NStage-2:0], in_fire};
      if (adv && vld_q[StLast]) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // ------------------------------------------------------------ input stage
  side_t              side_in;
  side_t              side_q [StG2+1];
  logic [31:0]        theta;
  logic [31:0]        theta_off;

  assign theta     = 32'd0 - {s_axis_tdata[63:48], 16'd0};
  assign theta_off = theta + 32'h2000_0000;

  always_comb begin
    side_in.x     = WW'($signed(s_axis_tdata[15:0])) <<< (WF - InFracBits);
    side_in.y     = WW'($signed(s_axis_tdata[31:16])) <<< (WF - InFracBits);
    side_in.rot   = WW'($signed(s_axis_tdata[47:32])) <<< (WF - InFracBits);
    side_in.hv    = s_axis_tuser[0];
    side_in.quad  = theta_off[31:30];
    side_in.resid = $signed(theta - {theta_off[31:30], 30'd0});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side_in;
      for (int k = 1; k <= StG2; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ------------------------------------- first rotation (by zero), then gain
  logic signed [WW-1:0]   c1x [Steps+1];
  logic signed [WW-1:0]   c1y [Steps+1];
  logic signed [AngW-1:0] c1z [Steps+1];

  assign c1x[0] = side_q[0].y;
  assign c1y[0] = side_q[0].x;
  assign c1z[0] = '0;

  for (genvar k = 0; k < Steps; k++) begin : g_rot1
    swk_cordic_cell #(.WW(WW), .STEP(k), .VECTOR(1'b0)) u_cell (
      .clk_i (clk_i), .ce_i (adv),
      .x_i (c1x[k]), .y_i (c1y[k]), .z_i (c1z[k]),
      .x_o (c1x[k+1]), .y_o (c1y[k+1]), .z_o (c1z[k+1])
    );
  end

  logic signed [WW-1:0] g1_str_q;
  logic signed [WW-1:0] g1_fwd_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_fwd_q <= mul_round(c1x[Steps], InvGain);
      g1_str_q <= mul_round(c1y[Steps], InvGain);
    end
  end

  // quadrant pre-rotation for the heading
  logic signed [WW-1:0]   q2x_q;
  logic signed [WW-1:0]   q2y_q;
  logic signed [AngW-1:0] q2z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q2z_q <= AngW'(side_q[StG1].resid);
      case (side_q[StG1].quad)
        2'd0: begin q2x_q <= g1_str_q;  q2y_q <= g1_fwd_q;  end
        2'd1: begin q2x_q <= -g1_fwd_q; q2y_q <= g1_str_q;  end
        2'd2: begin q2x_q <= -g1_str_q; q2y_q <= -g1_fwd_q; end
        default: begin q2x_q <= g1_fwd_q; q2y_q <= -g1_str_q; end
      endcase
    end
  end

  logic signed [WW-1:0]   c2x [Steps+1];
  logic signed [WW-1:0]   c2y [Steps+1];
  logic signed [AngW-1:0] c2z [Steps+1];

  assign c2x[0] = q2x_q;
  assign c2y[0] = q2y_q;
  assign c2z[0] = q2z_q;

  for (genvar k = 0; k < Steps; k++) begin : g_rot2
    swk_cordic_cell #(.WW(WW), .STEP(k), .VECTOR(1'b0)) u_cell (
      .clk_i (clk_i), .ce_i (adv),
      .x_i (c2x[k]), .y_i (c2y[k]), .z_i (c2z[k]),
      .x_o (c2x[k+1]), .y_o (c2y[k+1]), .z_o (c2z[k+1])
    );
  end

  logic signed [WW-1:0] g2x_q;
  logic signed [WW-1:0] g2y_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (side_q[StG2-1].hv) begin
        g2x_q <= mul_round(c2x[Steps], InvGain);
        g2y_q <= mul_round(c2y[Steps], InvGain);
      end else begin
        g2x_q <= side_q[StG2-1].x;
        g2y_q <= side_q[StG2-1].y;
      end
    end
  end

  // ------------------------------------------------------- rotate mixing
  logic signed [WW-1:0] mx_q, my_q, zl_q, zw_q;
  logic signed [WW-1:0] a_q, b_q, c_q, d_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx_q <= g2x_q;
      my_q <= g2y_q;
      zl_q <= mul_round(side_q[StG2].rot, rat.len_ratio);
      zw_q <= mul_round(side_q[StG2].rot, rat.wid_ratio);
      a_q  <= my_q - zl_q;
      b_q  <= my_q + zl_q;
      c_q  <= mx_q - zw_q;
      d_q  <= mx_q + zw_q;
    end
  end

  // ----------------------------------------------- per-wheel vectoring
  logic signed [WW-1:0]   lane_cos [Lanes];
  logic signed [WW-1:0]   lane_sin [Lanes];
  logic signed [WW-1:0]   vp_x_q [Lanes];
  logic signed [WW-1:0]   vp_y_q [Lanes];
  logic signed [AngW-1:0] vp_z_q [Lanes];
  logic [Lanes-1:0]       zf_q [Steps+1];

  assign lane_cos[0] = c_q;
  assign lane_sin[0] = b_q;
  assign lane_cos[1] = d_q;
  assign lane_sin[1] = b_q;
  assign lane_cos[2] = c_q;
  assign lane_sin[2] = a_q;
  assign lane_cos[3] = d_q;
  assign lane_sin[3] = a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < Lanes; l++) begin
        zf_q[0][l] <= (lane_cos[l] == '0) && (lane_sin[l] == '0);
        if (lane_cos[l] < 0) begin
          if (lane_sin[l] >= 0) begin
            vp_x_q[l] <= lane_sin[l];
            vp_y_q[l] <= -lane_cos[l];
            vp_z_q[l] <= QuarterTurn;
          end else begin
            vp_x_q[l] <= -lane_sin[l];
            vp_y_q[l] <= lane_cos[l];
            vp_z_q[l] <= -QuarterTurn;
          end
        end else begin
          vp_x_q[l] <= lane_cos[l];
          vp_y_q[l] <= lane_sin[l];
          vp_z_q[l] <= '0;
        end
      end
      for (int k = 1; k <= Steps; k++) zf_q[k] <= zf_q[k-1];
    end
  end

  logic signed [WW-1:0]   vx [Lanes][Steps+1];
  logic signed [WW-1:0]   vy [Lanes][Steps+1];
  logic signed [AngW-1:0] vz [Lanes][Steps+1];

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    assign vx[l][0] = vp_x_q[l];
    assign vy[l][0] = vp_y_q[l];
    assign vz[l][0] = vp_z_q[l];
    for (genvar k = 0; k < Steps; k++) begin : g_vec
      swk_cordic_cell #(.WW(WW), .STEP(k), .VECTOR(1'b1)) u_cell (
        .clk_i (clk_i), .ce_i (adv),
        .x_i (vx[l][k]), .y_i (vy[l][k]), .z_i (vz[l][k]),
        .x_o (vx[l][k+1]), .y_o (vy[l][k+1]), .z_o (vz[l][k+1])
      );
    end
  end

  // magnitude gain and angle scaling
  logic [DW-1:0]          mag_q [Lanes];
  logic [15:0]            ang_q [Lanes];
  logic signed [WW-1:0]   mag_r [Lanes];
  logic signed [AngW-1:0] ang_r [Lanes];
  logic signed [AngShift-1:0] ang_t [Lanes];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      mag_r[l] = mul_round(vx[l][Steps], InvGain);
      ang_r[l] = vz[l][Steps] + AngW'(AngRound);
      ang_t[l] = ang_r[l][AngW-1:AngW-AngShift];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < Lanes; l++) begin
        if (zf_q[Steps][l] || mag_r[l] < 0) mag_q[l] <= '0;
        else mag_q[l] <= mag_r[l][DW-1:0];
        if (zf_q[Steps][l]) ang_q[l] <= '0;
        else if (ang_t[l] > AngMax) ang_q[l] <= AngMax[15:0];
        else if (ang_t[l] < AngMin) ang_q[l] <= AngMin[15:0];
        else ang_q[l] <= ang_t[l][15:0];
      end
    end
  end

  // ------------------------------------------------ largest speed, division
  logic [DW-1:0] max01, max23, maxs;
  logic [DW-1:0] sm [Lanes];
  tail_t         tail_in;
  tail_t         tail_q [QuotW+1];
  logic [NW-1:0] num_q [Lanes];
  logic [DW-1:0] den_q;

  assign max01 = (mag_q[1] > mag_q[0]) ? mag_q[1] : mag_q[0];
  assign max23 = (mag_q[3] > mag_q[2]) ? mag_q[3] : mag_q[2];
  assign maxs  = (max23 > max01) ? max23 : max01;

  always_comb begin
    tail_in.big = maxs > (DW'(1) << WF);
    for (int l = 0; l < Lanes; l++) begin
      sm[l] = (mag_q[l] + DW'(SmallHalf)) >> (WF - InFracBits);
      tail_in.plain_spd[l] = (sm[l] > DW'(SpeedMax)) ? SpeedMax[15:0] : sm[l][15:0];
      tail_in.ang[l]       = ang_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tail_q[0] <= tail_in;
      for (int k = 1; k <= QuotW; k++) tail_q[k] <= tail_q[k-1];
      den_q <= maxs;
      for (int l = 0; l < Lanes; l++) begin
        num_q[l] <= (NW'(mag_q[l]) << InFracBits) + NW'(maxs >> 1);
      end
    end
  end

  logic [DW-1:0]    drem [Lanes][QuotW+1];
  logic [NW-1:0]    dnum [Lanes][QuotW+1];
  logic [DW-1:0]    dden [Lanes][QuotW+1];
  logic [QuotW-1:0] dquo [Lanes][QuotW+1];

  for (genvar l = 0; l < Lanes; l++) begin : g_div
    assign drem[l][0] = DW'(num_q[l] >> QuotW);
    assign dnum[l][0] = num_q[l];
    assign dden[l][0] = den_q;
    assign dquo[l][0] = '0;
    for (genvar k = 0; k < QuotW; k++) begin : g_bit
      swk_div_cell #(.DW(DW), .NW(NW), .BIT(QuotW - 1 - k)) u_cell (
        .clk_i (clk_i), .ce_i (adv),
        .rem_i (drem[l][k]), .num_i (dnum[l][k]),
        .den_i (dden[l][k]), .quo_i (dquo[l][k]),
        .rem_o (drem[l][k+1]), .num_o (dnum[l][k+1]),
        .den_o (dden[l][k+1]), .quo_o (dquo[l][k+1])
      );
    end
  end

  // ------------------------------------------------------- output register
  logic [QuotW-1:0] spd [Lanes];
  logic [127:0]     out_d;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      spd[l] = tail_q[QuotW].big ? dquo[l][QuotW] : {1'b0, tail_q[QuotW].plain_spd[l]};
      out_d[16*l +: 16] = (spd[l] > SpeedMax) ? SpeedMax[15:0] : spd[l][15:0];
      out_d[64 + 16*l +: 16] = tail_q[QuotW].ang[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[StLast]) out_data_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ------------------------------------------------------------ assertions
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> !s_axis_tready)
    else $error("input accepted right after a configuration write");

  a_load_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(vld_q[StLast]))
    else $error("output word appeared without a word in the last stage");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'h8000) && (m_axis_tdata[31:16] <= 16'h8000)
      && (m_axis_tdata[47:32] <= 16'h8000) && (m_axis_tdata[63:48] <= 16'h8000))
    else $error("wheel speed above 1.0");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[79:64]) <= 16'sd16384)
      && ($signed(m_axis_tdata[79:64]) >= -16'sd16384)
      && ($signed(m_axis_tdata[95:80]) <= 16'sd16384)
      && ($signed(m_axis_tdata[95:80]) >= -16'sd16384)
      && ($signed(m_axis_tdata[111:96]) <= 16'sd16384)
      && ($signed(m_axis_tdata[111:96]) >= -16'sd16384)
      && ($signed(m_axis_tdata[127:112]) <= 16'sd16384)
      && ($signed(m_axis_tdata[127:112]) >= -16'sd16384))
    else $error("steering angle beyond half a turn");

endmodule

`default_nettype wire

### tb/tb_swerve_wheel_kinematics_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swerve_wheel_kinematics_top
// Self-checking bench for the swerve kinematics block. Every command word is
// also run through a bit-exact fixed-point model of the datapath. The result
// words are compared in order, one field at a time, under bursty input, a
// random output stall and a sweep of wheelbase settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_swerve_wheel_kinematics_top;
  import swk_pkg::*;

  localparam int Steps = DefCordicSteps;
  localparam int Frac  = DefSampleBits + 4;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'd7;
  localparam int Latency = 3 * Steps + 26;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  swerve_wheel_kinematics_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  // wheelbase copy used by the model
  logic [CfgW-1:0] base_len = LengthReset;
  logic [CfgW-1:0] base_wid = WidthReset;

  logic [127:0] wheel_q[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int cfg_writes = 0;

  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;
  int hold_cycles = 0;
  int burst_left = 0;

  longint atan_step[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // sqrt(num^2 / (num^2 + other^2)) in q30
  function automatic longint axle_ratio(longint unsigned num, longint unsigned other);
    longint unsigned s;
    longint unsigned q;
    longint unsigned rem;
    s = num * num + other * other;
    if (s == 0) return 0;
    q = (num * num) / s;
    rem = (num * num) % s;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= s) begin
        rem = rem - s;
        q = q | 64'd1;
      end
    end
    return longint'(int_sqrt(q));
  endfunction

  task automatic rotate_vec(inout longint px, inout longint py, input int unsigned theta);
    int unsigned quad;
    int unsigned resid;
    longint z;
    longint x;
    longint y;
    longint t;
    longint dx;
    longint dy;
    quad = ((theta + 32'h2000_0000) >> 30) & 32'd3;
    resid = theta - (quad << 30);
    z = longint'({32'd0, resid});
    if (z >= (longint'(1) << 31)) z = z - (longint'(1) << 32);
    x = px;
    y = py;
    for (int i = 0; i < quad; i++) begin
      t = x;
      x = -y;
      y = t;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step[i];
      end
    end
    px = round_shift(x * 652032875, 30);
    py = round_shift(y * 652032875, 30);
  endtask

  task automatic wheel_polar(input longint xi, input longint yi,
                             output longint mag, output longint ang);
    longint x;
    longint y;
    longint z;
    longint t;
    longint dx;
    longint dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd1073741824;
      end else begin
        t = x; x = -y; y = t; z = -64'sd1073741824;
      end
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_step[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_step[i];
      end
    end
    mag = round_shift(x * 652032875, 30);
    if (mag < 0) mag = 0;
    t = round_shift(z, 17);
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    ang = t;
  endtask

  task automatic predict_wheels(input logic [63:0] cmd, input logic hv,
                                output logic [127:0] res);
    longint x;
    longint y;
    longint z;
    longint lr;
    longint wr;
    longint zl;
    longint zw;
    longint mag[4];
    longint ang[4];
    longint maxs;
    longint s;
    longint unsigned num;
    int unsigned theta;
    x = longint'($signed(cmd[15:0])) * 32;
    y = longint'($signed(cmd[31:16])) * 32;
    z = longint'($signed(cmd[47:32])) * 32;
    if (hv) begin
      rotate_vec(y, x, 32'd0);
      theta = 32'd0 - {cmd[63:48], 16'h0000};
      rotate_vec(x, y, theta);
    end
    lr = axle_ratio(base_len, base_wid);
    wr = axle_ratio(base_wid, base_len);
    zl = round_shift(z * lr, 30);
    zw = round_shift(z * wr, 30);
    wheel_polar(x - zw, y + zl, mag[0], ang[0]);
    wheel_polar(x + zw, y + zl, mag[1], ang[1]);
    wheel_polar(x - zw, y - zl, mag[2], ang[2]);
    wheel_polar(x + zw, y - zl, mag[3], ang[3]);
    maxs = mag[0];
    for (int k = 1; k < 4; k++) if (mag[k] > maxs) maxs = mag[k];
    for (int k = 0; k < 4; k++) begin
      if (maxs > (longint'(1) << Frac)) begin
        num = longint'(mag[k]) * 32768 + longint'(maxs) / 2;
        s = longint'(num / longint'(maxs));
      end else begin
        s = round_shift(mag[k], Frac - 15);
      end
      if (s > 32768) s = 32768;
      if (s < 0) s = 0;
      res[16*k +: 16] = s[15:0];
      res[64 + 16*k +: 16] = ang[k][15:0];
    end
  endtask

  // receiver: random stall, with one long hold in the backpressure test
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_on) begin
      m_axis_tready <= ($urandom_range(0, 9) > 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  string field_name[8] = '{"fl_speed", "fr_speed", "rl_speed", "rr_speed",
                           "fl_angle", "fr_angle", "rl_angle", "rr_angle"};

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (wheel_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        want = wheel_q.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (want[16*k +: 16] !== m_axis_tdata[16*k +: 16]) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, field_name[k],
                     want[16*k +: 16], m_axis_tdata[16*k +: 16]);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_cmd(input logic [15:0] st, input logic [15:0] fw,
                          input logic [15:0] rt, input logic [15:0] hd, input logic hv);
    logic [127:0] res;
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hd, rt, fw, st};
    s_axis_tuser <= hv;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_wheels({hd, rt, fw, st}, hv, res);
    wheel_q.push_back(res);
    words_in++;
  endtask

  task automatic end_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    end_input();
    while (wheel_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegLength) base_len = val;
    else if (idx == RegWidth) base_wid = val;
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_cmd(pick_field(), pick_field(), pick_field(), 16'($urandom),
               1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed();
    send_cmd(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // zero vector
    send_cmd(16'hc000, 16'h0000, 16'h0000, 16'h0000, 1'b0);  // straight backwards in x
    send_cmd(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 1'b0);
    send_cmd(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b0);
    send_cmd(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'h0000, 16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'h0000, 16'h0000, 16'h7fff, 16'h0000, 1'b0);
    send_cmd(16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    send_cmd(16'h4000, 16'h0000, 16'h0000, 16'h4000, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h0000, 16'h8000, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h1000, 16'h7fff, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h1000, 16'hc000, 1'b1);
    send_cmd(16'h4000, 16'h2000, 16'h1000, 16'hffff, 1'b1);
    send_cmd(16'h7fff, 16'h8000, 16'h4000, 16'h2000, 1'b1);
    send_cmd(16'h0001, 16'hffff, 16'h0001, 16'h0001, 1'b0);
    send_cmd(16'h1234, 16'hedcb, 16'h0000, 16'h1234, 1'b0);  // heading ignored
    drain();
  endtask

  task automatic test_wheelbase();
    logic [CfgW-1:0] lens[6] = '{12'd1, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd300};
    logic [CfgW-1:0] wids[6] = '{12'd4095, 12'd1, 12'd0, 12'd700, 12'd4095, 12'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(RegLength, lens[p]);
      write_reg(RegWidth, wids[p]);
      send_cmd(16'h2000, 16'h1000, 16'h7fff, 16'h0000, 1'b0);
      send_cmd(16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
      send_random(20);
      drain();
    end
    // writes to an unknown index must leave the wheelbase alone
    write_reg(RegUnused, 12'd9);
    send_random(10);
    drain();
  endtask

  task automatic test_random();
    gaps_on = 1'b1;
    stall_on = 1'b1;
    for (int p = 0; p < 4; p++) begin
      write_reg(RegLength, 12'($urandom_range(1, 4095)));
      write_reg(RegWidth, 12'($urandom_range(1, 4095)));
      send_random(80);
      stall_on = (p != 1);  // no output stall from the second phase's drain through the third phase's input
      drain();
    end
    stall_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_cycles = 400;
    send_random(120);
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_wheelbase();
    test_random();
    test_backpressure();
    write_reg(RegLength, LengthReset);
    write_reg(RegWidth, WidthReset);
    send_random(20);
    drain();
    $display("covered %0d commands, %0d result words, %0d register writes",
             words_in, words_out, cfg_writes);
    $display("wheelbase sweep incl. zero and full scale, bursty input, stalled output");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/swk_pkg.sv
hw/rtl/swk_cordic_cell.sv
hw/rtl/swk_div_cell.sv
hw/rtl/swk_ratio.sv
hw/rtl/swerve_wheel_kinematics_top.sv
tb/tb_swerve_wheel_kinematics_top.sv
